// File: hdl/dcr_pkg.sv
`timescale 1ns / 1ps
package dcr_pkg;
	localparam int SCREEN_W   = 128;
	localparam int SCREEN_H   = 64;
	localparam int PHASE_BITS = 10;
	localparam int QB         = PHASE_BITS - 2;
	localparam int QUARTER    = 1 << QB;

	localparam logic [1:0] REG_ANGLE_STEP    = 2'd0;
	localparam logic [1:0] REG_OUTER_SCALE   = 2'd1;
	localparam logic [1:0] REG_INNER_SCALE   = 2'd2;
	localparam logic [1:0] REG_VIEW_DISTANCE = 2'd3;

	localparam logic [7:0] CORNER_X = 8'b0110_0110;
	localparam logic [7:0] CORNER_Y = 8'b1100_1100;
	localparam logic [7:0] CORNER_Z = 8'b1111_0000;

	typedef logic [2:0] edge_tbl_t [12];
	localparam edge_tbl_t EDGE_A = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
	localparam edge_tbl_t EDGE_B = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
		3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

	typedef logic [14:0] sin_rom_t [QUARTER + 1];

	typedef struct packed {
		logic [9:0] angle_step;
		logic [7:0] outer_scale;
		logic [7:0] inner_scale;
		logic [3:0] view_distance;
	} cfg_t;

	typedef struct packed {
		logic                  valid;
		logic [PHASE_BITS-1:0] phase;
	} job_t;

	typedef struct packed {
		logic signed [9:0] start_x;
		logic signed [9:0] start_y;
		logic signed [9:0] end_x;
		logic signed [9:0] end_y;
		logic              cube_select;
		logic              last_segment;
	} seg_t;

	function automatic sin_rom_t build_sin_rom();
		sin_rom_t r;
		longint unsigned x, x2, p, v;
		for (int k = 0; k <= QUARTER; k++) begin
			x  = longint'(k) << (16 - QB);
			x2 = (x * x) >> 16;
			p  = 11;
			p  = 307 - ((p * x2) >> 16);
			p  = 5223 - ((p * x2) >> 16);
			p  = 42334 - ((p * x2) >> 16);
			p  = 102944 - ((p * x2) >> 16);
			v  = (p * x) >> 16;
			v  = (v + 2) >> 2;
			if (v > 16384) v = 16384;
			r[k] = v[14:0];
		end
		return r;
	endfunction

	localparam sin_rom_t SIN_ROM = build_sin_rom();

	function automatic logic signed [15:0] sin_q14(logic [PHASE_BITS-1:0] ph);
		logic [1:0]  quad;
		logic [QB:0] k;
		logic signed [15:0] v;
		quad = ph[PHASE_BITS-1 -: 2];
		k    = {1'b0, ph[QB-1:0]};
		if (quad[0]) k = (QB+1)'(QUARTER) - k;
		v = $signed({1'b0, SIN_ROM[k]});
		return quad[1] ? -v : v;
	endfunction
endpackage

// File: hdl/dcr_ram.sv
`timescale 1ns / 1ps
module dcr_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/dcr_front.sv
`timescale 1ns / 1ps
module dcr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          frame_tick,
	input  logic [9:0]    angle_step,
	input  logic          job_pop,
	output logic          full,
	output dcr_pkg::job_t job
);
	import dcr_pkg::*;

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] jq_q [2];
	logic                  wp_q, rp_q;
	logic [1:0]            cnt_q;
	logic                  wr;
	logic                  rd;

	assign full      = cnt_q == 2'd2;
	assign wr        = push && !full && frame_tick;
	assign rd        = job_pop && cnt_q != 2'd0;
	assign job.valid = cnt_q != 2'd0;
	assign job.phase = jq_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) jq_q[wp_q] <= phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (wr) begin
				phase_q <= phase_q + PHASE_BITS'(angle_step);
				wp_q    <= !wp_q;
			end
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

// File: hdl/dcr_engine.sv
`timescale 1ns / 1ps
module dcr_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  dcr_pkg::cfg_t cfg,
	input  dcr_pkg::job_t job,
	output logic          job_pop,
	input  logic          pop,
	output logic          empty,
	output dcr_pkg::seg_t head
);
	import dcr_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ROT  = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_ZR   = 9'b000001000,
		ST_DIV  = 9'b000010000,
		ST_PIX  = 9'b000100000,
		ST_WRP  = 9'b001000000,
		ST_ERD  = 9'b010000000,
		ST_EWR  = 9'b100000000
	} state_t;

	state_t state_q;
	logic signed [15:0] s_q, c_q;
	logic [2:0]  k_q;
	logic        m_q;
	logic signed [17:0] xr_q, yr_q, zt_q, ts_q, tc_q;
	logic [18:0] den_q;
	logic [19:0] rem_q;
	logic [29:0] dvd_q, quo_q;
	logic [4:0]  cnt_q;
	logic [15:0] f_q;
	logic signed [34:0] px_q, py_q;
	logic [4:0]  n_q;

	logic sx, sy, sz;
	logic signed [17:0] cc, ss, cy, sy_v;
	logic signed [33:0] pts, ptc;
	logic signed [19:0] zr, den;
	logic [19:0] rem_sh;
	logic        qbit;
	logic [9:0]  pix_x, pix_y;
	logic [3:0]  e_idx;
	logic [3:0]  ra, rb;
	logic [19:0] rda, rdb;
	logic        ram_we;
	seg_t        seg_in;

	seg_t        oq_q [2];
	logic        owp_q, orp_q;
	logic [1:0]  ocnt_q;
	logic        opush, opop;

	function automatic logic [9:0] to_pixel(logic signed [34:0] prod, int center);
		logic signed [35:0] sum;
		logic signed [13:0] t;
		sum = 36'(prod) + 36'(longint'(center) << 22);
		if (sum < 0) sum = sum + 36'((1 << 22) - 1);
		t = 14'(sum >>> 22);
		if (t < -14'sd256) t = -14'sd256;
		if (t > 14'sd511) t = 14'sd511;
		return t[9:0];
	endfunction

	function automatic logic signed [17:0] trunc14(logic signed [33:0] p);
		logic signed [33:0] a;
		a = (p < 0) ? p + 34'sd16383 : p;
		return 18'(a >>> 14);
	endfunction

	assign sx   = CORNER_X[k_q];
	assign sy   = CORNER_Y[k_q];
	assign sz   = CORNER_Z[k_q];
	assign cc   = 18'(c_q);
	assign ss   = 18'(s_q);
	assign cy   = sy ? cc : -cc;
	assign sy_v = sy ? ss : -ss;
	assign pts  = zt_q * s_q;
	assign ptc  = zt_q * c_q;
	assign zr   = 20'(sy_v) + 20'(tc_q);
	assign den  = zr + $signed({2'b0, cfg.view_distance, 14'b0});
	assign rem_sh = {rem_q[18:0], dvd_q[29]};
	assign qbit   = rem_sh >= {1'b0, den_q};
	assign pix_x  = to_pixel(px_q, SCREEN_W / 2);
	assign pix_y  = to_pixel(py_q, SCREEN_H / 2);
	assign ram_we = state_q == ST_WRP;

	assign e_idx = n_q[4:1];
	assign ra    = {n_q[0], EDGE_A[e_idx]};
	assign rb    = {n_q[0], EDGE_B[e_idx]};

	dcr_ram #(.WIDTH(20), .DEPTH(16)) u_ram_a (
		.clk(clk), .we(ram_we), .waddr({m_q, k_q}), .wdata({pix_x, pix_y}),
		.raddr(ra), .rdata(rda)
	);

	dcr_ram #(.WIDTH(20), .DEPTH(16)) u_ram_b (
		.clk(clk), .we(ram_we), .waddr({m_q, k_q}), .wdata({pix_x, pix_y}),
		.raddr(rb), .rdata(rdb)
	);

	assign seg_in.start_x      = $signed(rda[19:10]);
	assign seg_in.start_y      = $signed(rda[9:0]);
	assign seg_in.end_x        = $signed(rdb[19:10]);
	assign seg_in.end_y        = $signed(rdb[9:0]);
	assign seg_in.cube_select  = n_q[0];
	assign seg_in.last_segment = n_q == 5'd23;

	assign job_pop = state_q == ST_IDLE && job.valid;
	assign opush   = state_q == ST_EWR && ocnt_q != 2'd2;
	assign opop    = pop && !empty;
	assign empty   = ocnt_q == 2'd0;
	assign head    = oq_q[orp_q];

	always_ff @(posedge clk) begin
		if (opush) oq_q[owp_q] <= seg_in;
		case (state_q)
			ST_IDLE: begin
				s_q <= sin_q14(job.phase);
				c_q <= sin_q14(job.phase + PHASE_BITS'(QUARTER));
			end
			ST_ROT: begin
				xr_q <= (sx ? cc : -cc) - (sz ? ss : -ss);
				zt_q <= (sx ? ss : -ss) + (sz ? cc : -cc);
			end
			ST_MUL: begin
				ts_q <= trunc14(pts);
				tc_q <= trunc14(ptc);
			end
			ST_ZR: begin
				yr_q  <= cy - ts_q;
				den_q <= (den < 20'sd1) ? 19'd1 : den[18:0];
				dvd_q <= {cfg.outer_scale, 22'b0};
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= qbit ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[28:0], qbit};
				dvd_q <= {dvd_q[28:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd29)
					f_q <= (|quo_q[28:15]) ? 16'hFFFF : {quo_q[14:0], qbit};
			end
			ST_PIX: begin
				px_q <= xr_q * $signed({1'b0, f_q});
				py_q <= yr_q * $signed({1'b0, f_q});
			end
			ST_WRP: begin
				dvd_q <= {cfg.inner_scale, 22'b0};
				rem_q <= '0;
				cnt_q <= '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			m_q     <= 1'b0;
			n_q     <= '0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (opush) owp_q <= !owp_q;
			if (opop) orp_q <= !orp_q;
			ocnt_q <= ocnt_q + {1'b0, opush} - {1'b0, opop};
			case (state_q)
				ST_IDLE: if (job.valid) begin
					k_q     <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ZR;
				ST_ZR: begin
					m_q     <= 1'b0;
					state_q <= ST_DIV;
				end
				ST_DIV: if (cnt_q == 5'd29) state_q <= ST_PIX;
				ST_PIX: state_q <= ST_WRP;
				ST_WRP: begin
					if (!m_q) begin
						m_q     <= 1'b1;
						state_q <= ST_DIV;
					end else if (k_q == 3'd7) begin
						n_q     <= '0;
						state_q <= ST_ERD;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_ROT;
					end
				end
				ST_ERD: state_q <= ST_EWR;
				ST_EWR: if (opush) begin
					if (n_q == 5'd23) begin
						state_q <= ST_IDLE;
					end else begin
						n_q     <= n_q + 5'd1;
						state_q <= ST_ERD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/dual_cube_rotate_project.sv
`timescale 1ns / 1ps
// Wireframe renderer for two concentric cubes. Each pushed item with frame_tick
// set yields 24 segments (per edge: outer, then inner; last one flagged) and then
// advances the rotation phase by angle_step; an item with frame_tick clear yields
// nothing. The back end's time per frame is set mostly by the bit-serial divider
// that forms the 16 perspective factors, and by reading the segments out of the
// corner RAMs. Two frames may wait between the front queue and the back end;
// configuration writes are taken at any cycle.
module dual_cube_rotate_project (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              frame_tick,
	output logic              empty,
	input  logic              pop,
	output logic signed [9:0] start_x,
	output logic signed [9:0] start_y,
	output logic signed [9:0] end_x,
	output logic signed [9:0] end_y,
	output logic              cube_select,
	output logic              last_segment,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [9:0]        wr_data
);
	import dcr_pkg::*;

	cfg_t cfg_q;
	job_t job;
	logic job_pop;
	seg_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_step    <= 10'd8;
			cfg_q.outer_scale   <= 8'd28;
			cfg_q.inner_scale   <= 8'd14;
			cfg_q.view_distance <= 4'd3;
		end else if (wr_en) begin
			case (wr_index)
				REG_ANGLE_STEP:    cfg_q.angle_step    <= wr_data;
				REG_OUTER_SCALE:   cfg_q.outer_scale   <= wr_data[7:0];
				REG_INNER_SCALE:   cfg_q.inner_scale   <= wr_data[7:0];
				REG_VIEW_DISTANCE: cfg_q.view_distance <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	dcr_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .frame_tick(frame_tick),
		.angle_step(cfg_q.angle_step), .job_pop(job_pop), .full(full), .job(job)
	);

	dcr_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .job(job), .job_pop(job_pop),
		.pop(pop), .empty(empty), .head(head)
	);

	assign start_x      = head.start_x;
	assign start_y      = head.start_y;
	assign end_x        = head.end_x;
	assign end_y        = head.end_y;
	assign cube_select  = head.cube_select;
	assign last_segment = head.last_segment;
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import dcr_pkg::*;

	localparam longint ONE_Q14 = 16384;
	localparam longint SHIFT22 = 4194304;
	localparam int     SETTLE  = 1300;
	localparam int     WDOG    = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              frame_tick = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic signed [9:0] start_x, start_y, end_x, end_y;
	logic              cube_select, last_segment;
	logic              wr_en = 1'b0;
	logic [1:0]        wr_index = REG_ANGLE_STEP;
	logic [9:0]        wr_data = '0;

	dual_cube_rotate_project uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cfg_t              cfg;
	logic [PHASE_BITS-1:0] phase;
	seg_t              seg_q [$];
	int                errors = 0;
	int                frames = 0;
	int                segs = 0;
	int                cfg_writes = 0;
	int                holdoff = 0;
	int                quiet = 0;
	bit                no_idle = 1'b0;

	function automatic longint quarter_wave(int k);
		longint x, x2, p, v;
		x  = longint'(k) << (16 - QB);
		x2 = (x * x) >> 16;
		p  = 11;
		p  = 307 - ((p * x2) >> 16);
		p  = 5223 - ((p * x2) >> 16);
		p  = 42334 - ((p * x2) >> 16);
		p  = 102944 - ((p * x2) >> 16);
		v  = (p * x) >> 16;
		v  = (v + 2) >> 2;
		if (v > ONE_Q14) v = ONE_Q14;
		return v;
	endfunction

	function automatic longint wave(logic [PHASE_BITS-1:0] ph);
		int quad, k;
		longint v;
		quad = ph >> QB;
		k    = ph & (QUARTER - 1);
		if (quad & 1) k = QUARTER - k;
		v = quarter_wave(k);
		return (quad & 2) ? -v : v;
	endfunction

	function automatic logic [9:0] pixel(longint r, longint f, longint ctr);
		longint t;
		t = (r * f + ctr * SHIFT22) / SHIFT22;
		if (t < -256) t = -256;
		if (t > 511) t = 511;
		return t[9:0];
	endfunction

	task automatic render_frame();
		logic [9:0] px [2][8][2];
		longint s, c, x, y, z, xr, zt, yr, zr, den, f, sc;
		seg_t sg;
		int n;
		s = wave(phase);
		c = wave(phase + PHASE_BITS'(QUARTER));
		for (int k = 0; k < 8; k++) begin
			x   = CORNER_X[k] ? ONE_Q14 : -ONE_Q14;
			y   = CORNER_Y[k] ? ONE_Q14 : -ONE_Q14;
			z   = CORNER_Z[k] ? ONE_Q14 : -ONE_Q14;
			xr  = (x * c - z * s) / ONE_Q14;
			zt  = (x * s + z * c) / ONE_Q14;
			yr  = (y * c) / ONE_Q14 - (zt * s) / ONE_Q14;
			zr  = (y * s) / ONE_Q14 + (zt * c) / ONE_Q14;
			den = zr + longint'(cfg.view_distance) * ONE_Q14;
			if (den < 1) den = 1;
			for (int m = 0; m < 2; m++) begin
				sc = m ? longint'(cfg.inner_scale) : longint'(cfg.outer_scale);
				f  = sc * SHIFT22 / den;
				if (f > 65535) f = 65535;
				px[m][k][0] = pixel(xr, f, SCREEN_W / 2);
				px[m][k][1] = pixel(yr, f, SCREEN_H / 2);
			end
		end
		n = 0;
		for (int e = 0; e < 12; e++) begin
			for (int m = 0; m < 2; m++) begin
				sg.start_x      = px[m][EDGE_A[e]][0];
				sg.start_y      = px[m][EDGE_A[e]][1];
				sg.end_x        = px[m][EDGE_B[e]][0];
				sg.end_y        = px[m][EDGE_B[e]][1];
				sg.cube_select  = m[0];
				sg.last_segment = (n == 23);
				seg_q.push_back(sg);
				n++;
			end
		end
		phase = phase + cfg.angle_step;
		frames++;
	endtask

	task automatic send_item(bit tick);
		while (!no_idle && $urandom_range(99) < 19) begin
			push = 1'b0;
			@(negedge clk);
		end
		push       = 1'b1;
		frame_tick = tick;
		@(posedge clk);
		while (full) @(posedge clk);
		if (tick) render_frame();
		@(negedge clk);
	endtask

	task automatic drain();
		push = 1'b0;
		while (seg_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = val;
		case (idx)
			REG_ANGLE_STEP:    cfg.angle_step    = val;
			REG_OUTER_SCALE:   cfg.outer_scale   = val[7:0];
			REG_INNER_SCALE:   cfg.inner_scale   = val[7:0];
			REG_VIEW_DISTANCE: cfg.view_distance = val[3:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic set_all(logic [9:0] st, logic [7:0] os, logic [7:0] is, logic [3:0] vd);
		write_reg(REG_ANGLE_STEP, st);
		write_reg(REG_OUTER_SCALE, 10'(os));
		write_reg(REG_INNER_SCALE, 10'(is));
		write_reg(REG_VIEW_DISTANCE, 10'(vd));
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			pop = 1'b0;
		end else if (holdoff > 0) begin
			pop = 1'b0;
			holdoff--;
		end else begin
			pop = no_idle || ($urandom_range(99) >= 19);
		end
	end

	always @(posedge clk) begin
		seg_t want;
		if (arst_n && pop && !empty) begin
			segs++;
			if (seg_q.size() == 0) begin
				$display("%0t: unexpected segment (%0d,%0d)-(%0d,%0d)", $time,
					start_x, start_y, end_x, end_y);
				errors++;
			end else begin
				want = seg_q.pop_front();
				if (start_x !== want.start_x || start_y !== want.start_y ||
						end_x !== want.end_x || end_y !== want.end_y ||
						cube_select !== want.cube_select ||
						last_segment !== want.last_segment) begin
					$display({"%0t: expected (%0d,%0d)-(%0d,%0d) c%0d l%0d, ",
						"got (%0d,%0d)-(%0d,%0d) c%0d l%0d"},
						$time, want.start_x, want.start_y, want.end_x, want.end_y,
						want.cube_select, want.last_segment, start_x, start_y,
						end_x, end_y, cube_select, last_segment);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WDOG) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_reset_values();
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);
		send_item(1'b1);
		drain();
	endtask

	task automatic test_extremes();
		set_all(10'd1023, 8'd255, 8'd1, 4'd2);
		repeat (3) send_item(1'b1);
		drain();
		set_all(10'd0, 8'd1, 8'd255, 4'd15);
		repeat (2) send_item(1'b1);
		drain();
		set_all(10'd256, 8'd0, 8'd128, 4'd1);
		repeat (4) send_item(1'b1);
		drain();
		set_all(10'd77, 8'd200, 8'd0, 4'd0);
		repeat (5) send_item(1'b1);
		send_item(1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		set_all(10'd8, 8'd28, 8'd14, 4'd3);
		holdoff = 4000;
		repeat (8) send_item(1'b1);
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 11; ph++) begin
			set_all(10'($urandom_range(1023)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 4'($urandom_range(15)));
			no_idle = (ph == 4);
			repeat (20) send_item($urandom_range(99) < 85);
			drain();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		cfg   = '{angle_step: 10'd8, outer_scale: 8'd28, inner_scale: 8'd14,
			view_distance: 4'd3};
		phase = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_values();
		test_extremes();
		test_backpressure();
		test_random();
		$display("Covered %0d frames, %0d segments checked, %0d register writes,",
			frames, segs, cfg_writes);
		$display("extreme scales and distances, phase wrap and a long output stall.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
